>>> sv/mse_pkg.sv
package mse_pkg;

  localparam int unsigned MSE_MEM_WORDS = 65536;
  localparam logic [16:0] MSE_LIMIT_RST = 17'h10000;

  // Instruction kinds. The encodings match the input opcodes.
  typedef enum logic [3:0] {
    K_NOP  = 4'd0,
    K_ADD  = 4'd1,
    K_SUB  = 4'd2,
    K_MUL  = 4'd3,
    K_SLT  = 4'd4,
    K_ADDI = 4'd5,
    K_BEQ  = 4'd6,
    K_BNE  = 4'd7,
    K_J    = 4'd8,
    K_LW   = 4'd9,
    K_SW   = 4'd10
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_ADDR = 2'd2,
    ST_HALT = 2'd3
  } status_e;

  // Classified instruction, front to back.
  typedef struct packed {
    kind_e       kind;
    logic        zero_fault;
    logic [11:0] pc;
    logic [4:0]  dest;
    logic [4:0]  rd1;
    logic [4:0]  rd2;
    logic [31:0] imm1;
    logic [31:0] imm2;
    logic        imm1_sel;
    logic        imm2_sel;
    logic [11:0] target;
  } uop_t;

  typedef struct packed {
    logic [12:0] next_pc;
    status_e     status;
    logic        we;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic [31:0] retired;
  } res_t;

endpackage

>>> sv/mse_front.sv
module mse_front import mse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [3:0]         op_i,
  input  logic [11:0]        pc_i,
  input  logic [4:0]         dest_reg_i,
  input  logic [4:0]         src1_reg_i,
  input  logic [4:0]         src2_reg_i,
  input  logic signed [31:0] src1_imm_i,
  input  logic signed [31:0] src2_imm_i,
  input  logic               src1_is_imm_i,
  input  logic               src2_is_imm_i,
  input  logic [11:0]        jump_target_i,
  input  logic               busy_i,
  output logic               q_valid_o,
  output uop_t               q_uop_o,
  input  logic               q_pop_i
);

  uop_t        uop;
  logic        writes;
  logic        push_ok;
  uop_t        q_mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  always_comb begin
    uop = '0;
    if (op_i <= 4'(K_SW)) begin
      uop.kind = kind_e'(op_i);
    end else begin
      uop.kind = K_NOP;
    end
    writes = (uop.kind == K_ADD) || (uop.kind == K_SUB) || (uop.kind == K_MUL) ||
             (uop.kind == K_SLT) || (uop.kind == K_ADDI) || (uop.kind == K_LW);
    uop.zero_fault = writes && (dest_reg_i == 5'd0);
    uop.pc         = pc_i;
    uop.dest       = dest_reg_i;
    uop.rd1        = src1_reg_i;
    // sw reads the stored register on the second port
    uop.rd2        = (uop.kind == K_SW) ? dest_reg_i : src2_reg_i;
    uop.imm1       = src1_imm_i;
    uop.imm2       = src2_imm_i;
    uop.imm1_sel   = src1_is_imm_i;
    uop.imm2_sel   = src2_is_imm_i;
    uop.target     = jump_target_i;
  end

  assign full_o    = busy_i || (cnt_q == 2'd2);
  assign push_ok   = push_i && !full_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_uop_o   = q_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_mem_q[wp_q] <= uop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_ok) begin
        wp_q <= ~wp_q;
      end
      if (q_pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_ok) - 2'(q_pop_i);
    end
  end

endmodule

>>> sv/mse_back.sv
module mse_back import mse_pkg::*; #(
  parameter int unsigned MEM_WORDS = MSE_MEM_WORDS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        q_valid_i,
  input  uop_t        q_uop_i,
  output logic        q_pop_o,
  input  logic        res_ready_i,
  output logic        res_push_o,
  output res_t        res_o,
  output logic        busy_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  typedef enum logic [2:0] {
    S_EMPTY = 3'b001,
    S_EXEC  = 3'b010,
    S_LOAD  = 3'b100
  } state_e;

  state_e      state_q, state_d;
  uop_t        ex_q;
  logic        halted_q;
  logic [31:0] retired_q;
  logic [16:0] limit_q;
  logic        clr_busy_q;
  logic [AW-1:0] clr_idx_q;

  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic [31:0] rd1_raw_q, rd2_raw_q, byp_val_q;
  logic        rd1_ok_q, rd2_ok_q, byp1_q, byp2_q;

  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] ld_data_q;

  logic [31:0] a, b, opx, opy, val;
  logic [32:0] addr_sum, lim;
  logic        addr_bad;
  logic [12:0] nxt;
  status_e     status;
  logic        we, is_ld, is_st, retire;
  logic        exec_done, load_go, load_done, done, issue;
  logic        wb_en;
  logic [4:0]  wb_idx;
  logic [31:0] wb_val;
  logic        dm_we;
  logic [AW-1:0] dm_waddr;
  logic [31:0] dm_wdata;
  logic [AW-1:0] dm_addr;

  assign a = byp1_q ? byp_val_q : (rd1_ok_q ? rd1_raw_q : 32'd0);
  assign b = byp2_q ? byp_val_q : (rd2_ok_q ? rd2_raw_q : 32'd0);

  always_comb begin
    addr_sum = {a[31], a} + {ex_q.imm2[31], ex_q.imm2};
    lim      = (33'(limit_q) < 33'(MEM_WORDS)) ? 33'(limit_q) : 33'(MEM_WORDS);
    addr_bad = addr_sum[32] || (addr_sum >= lim);
    dm_addr  = addr_sum[AW-1:0];
    opx      = ex_q.imm1_sel ? ex_q.imm1 : a;
    opy      = ex_q.imm2_sel ? ex_q.imm2 : b;
    status   = ST_OK;
    val      = 32'd0;
    we       = 1'b0;
    is_ld    = 1'b0;
    is_st    = 1'b0;
    nxt      = {1'b0, ex_q.pc} + 13'd1;
    if (halted_q) begin
      status = ST_HALT;
      nxt    = {1'b0, ex_q.pc};
    end else if (ex_q.zero_fault) begin
      status = ST_ZERO;
    end else begin
      unique case (ex_q.kind)
        K_NOP: ;
        K_ADD: begin val = a + b; we = 1'b1; end
        K_SUB: begin val = a - b; we = 1'b1; end
        K_MUL: begin val = a * b; we = 1'b1; end
        K_SLT: begin val = {31'd0, $signed(a) < $signed(b)}; we = 1'b1; end
        K_ADDI: begin val = opx + opy; we = 1'b1; end
        K_BEQ: if (a == b) nxt = {1'b0, ex_q.target};
        K_BNE: if (a != b) nxt = {1'b0, ex_q.target};
        K_J:   nxt = {1'b0, ex_q.target};
        K_LW: begin
          if (addr_bad) status = ST_ADDR;
          else          is_ld  = 1'b1;
        end
        K_SW: begin
          if (addr_bad) status = ST_ADDR;
          else          is_st  = 1'b1;
        end
        default: ;
      endcase
      if (status != ST_OK) begin
        nxt = {1'b0, ex_q.pc};
        we  = 1'b0;
        val = 32'd0;
      end
    end
    retire = !halted_q && (status == ST_OK) && (ex_q.kind != K_NOP);
  end

  assign exec_done  = (state_q == S_EXEC) && !is_ld && res_ready_i;
  assign load_go    = (state_q == S_EXEC) && is_ld;
  assign load_done  = (state_q == S_LOAD) && res_ready_i;
  assign done       = exec_done || load_done;
  assign issue      = q_valid_i && ((state_q == S_EMPTY) || done);
  assign q_pop_o    = issue;
  assign res_push_o = done;
  assign busy_o     = clr_busy_q;

  assign wb_en  = (exec_done && we) || load_done;
  assign wb_idx = ex_q.dest;
  assign wb_val = (state_q == S_LOAD) ? ld_data_q : val;

  always_comb begin
    if (state_q == S_LOAD) begin
      res_o.next_pc = {1'b0, ex_q.pc} + 13'd1;
      res_o.status  = ST_OK;
      res_o.we      = 1'b1;
      res_o.widx    = ex_q.dest;
      res_o.wval    = ld_data_q;
      res_o.retired = retired_q + 32'd1;
    end else begin
      res_o.next_pc = nxt;
      res_o.status  = status;
      res_o.we      = we;
      res_o.widx    = we ? ex_q.dest : 5'd0;
      res_o.wval    = val;
      res_o.retired = retired_q + 32'(retire);
    end
  end

  always_comb begin
    state_d = state_q;
    if (issue) begin
      state_d = S_EXEC;
    end else if (load_go) begin
      state_d = S_LOAD;
    end else if (done) begin
      state_d = S_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_EMPTY;
      halted_q   <= 1'b0;
      retired_q  <= 32'd0;
      limit_q    <= MSE_LIMIT_RST;
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      state_q <= state_d;
      if (exec_done && (status == ST_ZERO || status == ST_ADDR)) begin
        halted_q <= 1'b1;
      end
      if ((exec_done && retire) || load_done) begin
        retired_q <= retired_q + 32'd1;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (clr_busy_q) begin
        if (clr_idx_q == AW'(MEM_WORDS - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_idx_q <= clr_idx_q + 1'b1;
        end
      end
    end
  end

  // register file: one write port, two registered read ports, bypass from writeback
  always_ff @(posedge clk_i) begin
    if (wb_en) begin
      rf_mem[wb_idx] <= wb_val;
    end
    if (issue) begin
      rd1_raw_q <= rf_mem[q_uop_i.rd1];
      rd2_raw_q <= rf_mem[q_uop_i.rd2];
      byp_val_q <= wb_val;
      ex_q      <= q_uop_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      rd1_ok_q <= 1'b0;
      rd2_ok_q <= 1'b0;
      byp1_q   <= 1'b0;
      byp2_q   <= 1'b0;
    end else begin
      if (wb_en) begin
        rf_vld_q[wb_idx] <= 1'b1;
      end
      if (issue) begin
        rd1_ok_q <= rf_vld_q[q_uop_i.rd1] && (q_uop_i.rd1 != 5'd0);
        rd2_ok_q <= rf_vld_q[q_uop_i.rd2] && (q_uop_i.rd2 != 5'd0);
        byp1_q   <= wb_en && (wb_idx == q_uop_i.rd1) && (q_uop_i.rd1 != 5'd0);
        byp2_q   <= wb_en && (wb_idx == q_uop_i.rd2) && (q_uop_i.rd2 != 5'd0);
      end
    end
  end

  // data memory: clearing pass after reset, then sw writes
  always_comb begin
    if (clr_busy_q) begin
      dm_we    = 1'b1;
      dm_waddr = clr_idx_q;
      dm_wdata = 32'd0;
    end else begin
      dm_we    = exec_done && is_st;
      dm_waddr = dm_addr;
      dm_wdata = b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dmem[dm_waddr] <= dm_wdata;
    end
    if (load_go) begin
      ld_data_q <= dmem[dm_addr];
    end
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared");

  a_wb_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_en |-> (wb_idx != 5'd0 && !halted_q))
    else $error("illegal register writeback");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (state_q == S_EMPTY && !q_valid_i))
    else $error("item in flight during memory clear");

  a_retire_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (retired_q == $past(retired_q) || retired_q == $past(retired_q) + 32'd1))
    else $error("retired count jumped");

endmodule

>>> sv/mse_resq.sv
module mse_resq import mse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic ready_o,
  input  res_t res_i,
  output logic empty_o,
  input  logic pop_i,
  output res_t res_o
);

  res_t       q_mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push_ok, pop_ok;

  assign ready_o = (cnt_q != 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign push_ok = push_i && ready_o;
  assign pop_ok  = pop_i && !empty_o;
  assign res_o   = q_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_mem_q[wp_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_ok) begin
        wp_q <= ~wp_q;
      end
      if (pop_ok) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_ok) - 2'(pop_ok);
    end
  end

endmodule

>>> sv/mips_subset_execute.sv
// Executes one decoded instruction of a small MIPS-like subset per item and
// returns one result item per input item, in order. Items enter through a
// two-entry queue (push/full) and results leave through a two-entry queue
// (empty/pop). The execute stage registers its register file reads when it
// takes an item, then finishes add, sub, mul, slt, addi, branches, j, sw and
// nop, so it completes one such item per cycle while the result queue has
// room; lw goes on to a load state because the data memory read is
// registered. After reset the data memory is cleared one word per cycle,
// over all MEM_WORDS words, while full stays high; mem_limit writes are
// taken at any time and should be made only while the block is idle. A
// fault halts the block; later items report halted.
module mips_subset_execute import mse_pkg::*; #(
  parameter int unsigned MEM_WORDS = MSE_MEM_WORDS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [16:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         op_i,
  input  logic [11:0]        pc_i,
  input  logic [4:0]         dest_reg_i,
  input  logic [4:0]         src1_reg_i,
  input  logic [4:0]         src2_reg_i,
  input  logic signed [31:0] src1_imm_i,
  input  logic signed [31:0] src2_imm_i,
  input  logic               src1_is_imm_i,
  input  logic               src2_is_imm_i,
  input  logic [11:0]        jump_target_i,
  output logic               empty,
  input  logic               pop,
  output logic [12:0]        next_pc_o,
  output logic [1:0]         status_o,
  output logic               write_enable_o,
  output logic [4:0]         write_index_o,
  output logic signed [31:0] write_value_o,
  output logic [31:0]        retired_count_o
);

  logic busy;
  logic q_valid, q_pop;
  uop_t q_uop;
  logic res_ready, res_push;
  res_t res_in, res_out;

  mse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .op_i          (op_i),
    .pc_i          (pc_i),
    .dest_reg_i    (dest_reg_i),
    .src1_reg_i    (src1_reg_i),
    .src2_reg_i    (src2_reg_i),
    .src1_imm_i    (src1_imm_i),
    .src2_imm_i    (src2_imm_i),
    .src1_is_imm_i (src1_is_imm_i),
    .src2_is_imm_i (src2_is_imm_i),
    .jump_target_i (jump_target_i),
    .busy_i        (busy),
    .q_valid_o     (q_valid),
    .q_uop_o       (q_uop),
    .q_pop_i       (q_pop)
  );

  mse_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_uop_i     (q_uop),
    .q_pop_o     (q_pop),
    .res_ready_i (res_ready),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .busy_o      (busy)
  );

  mse_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .ready_o (res_ready),
    .res_i   (res_in),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res_out)
  );

  assign next_pc_o       = res_out.next_pc;
  assign status_o        = res_out.status;
  assign write_enable_o  = res_out.we;
  assign write_index_o   = res_out.widx;
  assign write_value_o   = res_out.wval;
  assign retired_count_o = res_out.retired;

endmodule

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mse_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam logic [3:0]  OP_UNUSED_MIN  = 4'd11;
  localparam logic [3:0]  OP_UNUSED_MAX  = 4'd15;

  typedef struct {
    logic [3:0]  op;
    logic [11:0] pc;
    logic [4:0]  rd;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [31:0] imm1;
    logic [31:0] imm2;
    logic        sel1;
    logic        sel2;
    logic [11:0] target;
  } instr_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [16:0]        cfg_wdata_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic [3:0]         op_i = '0;
  logic [11:0]        pc_i = '0;
  logic [4:0]         dest_reg_i = '0;
  logic [4:0]         src1_reg_i = '0;
  logic [4:0]         src2_reg_i = '0;
  logic signed [31:0] src1_imm_i = '0;
  logic signed [31:0] src2_imm_i = '0;
  logic               src1_is_imm_i = 1'b0;
  logic               src2_is_imm_i = 1'b0;
  logic [11:0]        jump_target_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [12:0]        next_pc_o;
  logic [1:0]         status_o;
  logic               write_enable_o;
  logic [4:0]         write_index_o;
  logic signed [31:0] write_value_o;
  logic [31:0]        retired_count_o;

  mips_subset_execute DUT (.*);

  // architectural state as the core should see it
  logic [31:0] gpr [32];
  logic [31:0] dmem [int];
  logic        halted_q = 1'b0;
  logic [31:0] retired_q = '0;
  logic [16:0] mem_limit_q = MSE_LIMIT_RST;

  res_t        pending_results [$];
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  string       fault_note = "none";

  initial foreach (gpr[i]) gpr[i] = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint mem_window();
    return (mem_limit_q < MSE_MEM_WORDS) ? longint'(mem_limit_q) : longint'(MSE_MEM_WORDS);
  endfunction

  function automatic res_t execute_instr(instr_t it);
    res_t        r;
    logic [31:0] a, b, x, y, val;
    logic        writes, we;
    longint      addr;
    a = gpr[it.rs];
    b = gpr[it.rt];
    r = '0;
    r.next_pc = {1'b0, it.pc} + 13'd1;
    r.status = ST_OK;
    we = 1'b0;
    val = '0;
    if (halted_q) begin
      r.status = ST_HALT;
      r.next_pc = {1'b0, it.pc};
    end else begin
      writes = (it.op >= K_ADD && it.op <= K_ADDI) || it.op == K_LW;
      if (writes && it.rd == 5'd0) begin
        r.status = ST_ZERO;
      end else begin
        case (it.op)
          K_ADD: begin val = a + b; we = 1'b1; end
          K_SUB: begin val = a - b; we = 1'b1; end
          K_MUL: begin val = a * b; we = 1'b1; end
          K_SLT: begin val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0; we = 1'b1; end
          K_ADDI: begin
            x = it.sel1 ? it.imm1 : a;
            y = it.sel2 ? it.imm2 : b;
            val = x + y;
            we = 1'b1;
          end
          K_BEQ: if (a == b) r.next_pc = {1'b0, it.target};
          K_BNE: if (a != b) r.next_pc = {1'b0, it.target};
          K_J: r.next_pc = {1'b0, it.target};
          K_LW, K_SW: begin
            addr = longint'($signed(a)) + longint'($signed(it.imm2));
            if (addr < 0 || addr >= mem_window()) begin
              r.status = ST_ADDR;
            end else if (it.op == K_LW) begin
              val = dmem.exists(int'(addr)) ? dmem[int'(addr)] : 32'd0;
              we = 1'b1;
            end else begin
              dmem[int'(addr)] = gpr[it.rd];
            end
          end
          default: ;
        endcase
      end
      if (r.status != ST_OK) begin
        halted_q = 1'b1;
        r.next_pc = {1'b0, it.pc};
        we = 1'b0;
        val = '0;
      end else begin
        if (we) gpr[it.rd] = val;
        if (it.op >= K_ADD && it.op <= K_SW) retired_q = retired_q + 32'd1;
      end
    end
    r.we = we;
    r.widx = we ? it.rd : 5'd0;
    r.wval = we ? val : 32'd0;
    r.retired = retired_q;
    return r;
  endfunction

  function automatic instr_t mk(logic [3:0] op, logic [11:0] pc, logic [4:0] rd, logic [4:0] rs,
                                logic [4:0] rt, logic [31:0] i1, logic [31:0] i2, logic s1,
                                logic s2, logic [11:0] tgt);
    instr_t it;
    it.op = op;
    it.pc = pc;
    it.rd = rd;
    it.rs = rs;
    it.rt = rt;
    it.imm1 = i1;
    it.imm2 = i2;
    it.sel1 = s1;
    it.sel2 = s2;
    it.target = tgt;
    return it;
  endfunction

  // load/store hitting addr; falls back to base r0 when the offset won't fit
  function automatic instr_t mem_access(kind_e k, logic [4:0] rd, logic [4:0] base, longint addr);
    longint off;
    off = addr - longint'($signed(gpr[base]));
    if (off != longint'(int'(off))) begin
      base = 5'd0;
      off = addr;
    end
    return mk(k, 12'($urandom), rd, base, 5'($urandom), $urandom, off[31:0],
              1'($urandom), 1'($urandom), 12'($urandom));
  endfunction

  function automatic logic [31:0] rand_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) begin
      case ($urandom_range(4))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'hFFFF_FFFF;
        3: return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    if (r < 50) return 32'($urandom_range(0, 63)) - 32'd32;
    return $urandom;
  endfunction

  function automatic longint pick_addr(longint lim);
    int unsigned r, span;
    r = $urandom_range(99);
    if (r < 50) begin
      span = (lim > 16) ? 15 : int'(lim) - 1;
      return longint'($urandom_range(0, span));
    end
    if (r < 70) begin
      span = (lim > 4) ? 3 : int'(lim) - 1;
      return lim - 1 - longint'($urandom_range(0, span));
    end
    return longint'($urandom_range(0, int'(lim) - 1));
  endfunction

  function automatic instr_t random_instr();
    instr_t      it;
    int unsigned r;
    longint      lim;
    r = $urandom_range(99);
    lim = mem_window();
    it = mk(K_NOP, 12'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), rand_word(),
            rand_word(), 1'($urandom), 1'($urandom), 12'($urandom));
    if (r < 4)       it.op = K_NOP;
    else if (r < 6)  it.op = 4'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
    else if (r < 16) it.op = K_ADD;
    else if (r < 24) it.op = K_SUB;
    else if (r < 32) it.op = K_MUL;
    else if (r < 40) it.op = K_SLT;
    else if (r < 60) it.op = K_ADDI;
    else if (r < 67) it.op = K_BEQ;
    else if (r < 74) it.op = K_BNE;
    else if (r < 78) it.op = K_J;
    else if (r < 89) it.op = K_LW;
    else             it.op = K_SW;
    if ((it.op == K_LW || it.op == K_SW) && lim == 0) it.op = K_ADDI;
    if ((it.op >= K_ADD && it.op <= K_ADDI) || it.op == K_LW) it.rd = 5'($urandom_range(1, 31));
    if ((it.op == K_BEQ || it.op == K_BNE) && $urandom_range(2) == 0) it.rt = it.rs;
    if (it.op == K_LW || it.op == K_SW)
      it = mem_access(kind_e'(it.op), it.rd, it.rs, pick_addr(lim));
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t: result %0d %s: got %0h, expected %0h", $realtime, results_seen, what, got,
               want);
  endtask

  task automatic send_item(instr_t it);
    res_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    op_i <= it.op;
    pc_i <= it.pc;
    dest_reg_i <= it.rd;
    src1_reg_i <= it.rs;
    src2_reg_i <= it.rt;
    src1_imm_i <= it.imm1;
    src2_imm_i <= it.imm2;
    src1_is_imm_i <= it.sel1;
    src2_is_imm_i <= it.sel2;
    jump_target_i <= it.target;
    do @(posedge clk_i); while (full);
    want = execute_instr(it);
    pending_results = {pending_results, want};
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_mem_limit(logic [16:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mem_limit_q = value;
  endtask

  always @(negedge clk_i) pop <= ($urandom_range(99) >= pop_stall_pct);

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (pop && !empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("arrived with nothing pending", 32'(next_pc_o), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (next_pc_o !== want.next_pc)
          report_mismatch("next_pc", 32'(next_pc_o), 32'(want.next_pc));
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (write_enable_o !== want.we)
          report_mismatch("write_enable", 32'(write_enable_o), 32'(want.we));
        if (write_index_o !== want.widx)
          report_mismatch("write_index", 32'(write_index_o), 32'(want.widx));
        if (write_value_o !== want.wval)
          report_mismatch("write_value", write_value_o, want.wval);
        if (retired_count_o !== want.retired)
          report_mismatch("retired_count", retired_count_o, want.retired);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results pending", stall_cycles,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_directed_ops();
    send_item(mk(K_ADDI, 12'd0, 5'd1, 5'd0, 5'd0, 32'h7FFF_FFFF, 32'h1, 1'b1, 1'b1, 12'd0));
    send_item(mk(K_ADDI, 12'd1, 5'd2, 5'd0, 5'd1, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 12'd0));
    send_item(mk(K_ADDI, 12'd2, 5'd3, 5'd2, 5'd0, 32'h0, 32'h8000_0000, 1'b0, 1'b1, 12'd0));
    send_item(mk(K_ADDI, 12'hFFF, 5'd4, 5'd1, 5'd3, 32'h0, 32'h0, 1'b0, 1'b0, 12'd0));
    send_item(mk(K_ADD, 12'd5, 5'd5, 5'd1, 5'd1, 32'h0, 32'h0, 1'b0, 1'b0, 12'd0));
    send_item(mk(K_SUB, 12'd6, 5'd6, 5'd1, 5'd2, 32'h0, 32'h0, 1'b0, 1'b0, 12'd0));
    send_item(mk(K_MUL, 12'd7, 5'd7, 5'd3, 5'd3, 32'h0, 32'h0, 1'b0, 1'b0, 12'd0));
    send_item(mk(K_MUL, 12'd8, 5'd8, 5'd2, 5'd1, 32'h0, 32'h0, 1'b0, 1'b0, 12'd0));
    send_item(mk(K_SLT, 12'd9, 5'd9, 5'd1, 5'd2, 32'h0, 32'h0, 1'b0, 1'b0, 12'd0));
    send_item(mk(K_SLT, 12'd10, 5'd10, 5'd2, 5'd1, 32'h0, 32'h0, 1'b0, 1'b0, 12'd0));
    send_item(mk(K_BEQ, 12'd11, 5'd0, 5'd5, 5'd0, 32'h0, 32'h0, 1'b0, 1'b0, 12'hFFF));
    send_item(mk(K_BEQ, 12'd12, 5'd0, 5'd1, 5'd2, 32'h0, 32'h0, 1'b0, 1'b0, 12'h123));
    send_item(mk(K_BNE, 12'd13, 5'd0, 5'd1, 5'd2, 32'h0, 32'h0, 1'b0, 1'b0, 12'd0));
    send_item(mk(K_BNE, 12'd14, 5'd0, 5'd5, 5'd0, 32'h0, 32'h0, 1'b0, 1'b0, 12'h456));
    send_item(mk(K_J, 12'hFFF, 5'd0, 5'd0, 5'd0, 32'h0, 32'h0, 1'b0, 1'b0, 12'h800));
    send_item(mem_access(K_SW, 5'd2, 5'd0, 0));
    send_item(mem_access(K_SW, 5'd3, 5'd2, 65535));
    send_item(mem_access(K_LW, 5'd11, 5'd1, 0));
    send_item(mem_access(K_LW, 5'd12, 5'd0, 65535));
    send_item(mem_access(K_LW, 5'd13, 5'd4, 1234));
    send_item(mem_access(K_SW, 5'd0, 5'd6, 1));
    send_item(mk(K_NOP, 12'd17, 5'd0, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
                 12'hFFF));
    send_item(mk(OP_UNUSED_MAX, 12'd18, 5'd0, 5'd3, 5'd2, 32'h0, 32'h0, 1'b0, 1'b0, 12'd0));
    send_item(mk(K_ADDI, 12'hFFF, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
                 12'hFFF));
  endtask

  task automatic test_mem_limit_edges();
    wait_drain();
    set_mem_limit(17'd1);
    send_item(mem_access(K_SW, 5'd2, 5'd0, 0));
    send_item(mem_access(K_LW, 5'd14, 5'd6, 0));
    wait_drain();
    set_mem_limit(17'd0);
    repeat (4) send_item(random_instr());
    wait_drain();
    set_mem_limit(17'h1FFFF);
    send_item(mem_access(K_SW, 5'd7, 5'd2, 65535));
    send_item(mem_access(K_LW, 5'd15, 5'd0, 65535));
  endtask

  task automatic test_random_phase(int unsigned idle_in, int unsigned stall_out,
                                   logic [16:0] limit, int unsigned count);
    int unsigned i;
    wait_drain();
    set_mem_limit(limit);
    send_idle_pct = idle_in;
    pop_stall_pct = stall_out;
    for (i = 0; i < count; i++) begin
      // let the pipeline run dry now and then
      if (i == count / 2 || $urandom_range(199) == 0) wait_drain();
      send_item(random_instr());
    end
  endtask

  task automatic test_fault_halt();
    instr_t      it;
    int unsigned r;
    longint      lim, bad;
    lim = mem_window();
    bad = ($urandom_range(1) == 0) ? -1 - longint'($urandom_range(0, 100))
                                   : lim + longint'($urandom_range(0, 100));
    case ($urandom_range(2))
      0: begin
        fault_note = "zero register write";
        it = random_instr();
        r = $urandom_range(5);
        it.op = (r == 5) ? 4'(K_LW) : 4'(K_ADD + r);
        it.rd = 5'd0;
      end
      1: begin
        fault_note = "address out of range";
        it = mem_access(($urandom_range(1) == 0) ? K_LW : K_SW, 5'($urandom_range(1, 31)),
                        5'($urandom), bad);
      end
      default: begin
        fault_note = "zero register load with bad address";
        it = mem_access(K_LW, 5'd0, 5'($urandom), bad);
      end
    endcase
    send_item(it);
    repeat (10) send_item(random_instr());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_directed_ops();
    test_mem_limit_edges();
    test_random_phase(0, 0, MSE_LIMIT_RST, 360);
    test_random_phase(68, 0, 17'($urandom_range(1, 65536)), 360);
    test_random_phase(0, 68, 17'd16, 360);
    test_random_phase(23, 23, 17'h1FFFF, 360);
    test_fault_halt();
    wait_drain();
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d items and %0d results, %0d mismatches, retired count %0d.",
             items_sent, results_seen, mismatches, retired_q);
    $display("Memory limits 0, 1, 16, random, 65536 and 131071; closing fault: %s.", fault_note);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
